>>> rtl/assert_macros.svh
// Assertion macros used by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while reset is released.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle while reset is released.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/lkvc_pkg.sv
// Types and constants of the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CAP_RESET   = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 5;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_UPD
    } t_state;

endpackage

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with LRU replacement over one entry memory.
`default_nettype none

`include "assert_macros.svh"

// A get (tuser 0) looks up tdata[31:0] and returns one result: tuser = hit,
// tdata = stored value, or all ones on a miss. A put (tuser 1) stores
// tdata[63:32] under key tdata[31:0] and returns nothing; when the store
// already holds capacity entries, the least recently used entry is replaced.
// Entries live in one memory (key, value, recency rank) with a registered read.
// Each item first scans the memory one entry per cycle to find the key, a free
// slot and the oldest entry, then, when recency changes, sweeps it again with a
// read-modify-write of each rank: a get miss needs only the scan, a put and a
// get hit both sweeps. Capacity writes (clamped to 1..ENTRIES) take effect only
// while the cache is empty. A finished result waits in an output register, so
// the next item can be taken while it is not yet read.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // configuration: capacity
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_W-1:0]        i_cfg_data,
    // requests
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire  [KEY_W+VAL_W-1:0]  i_s_axis_tdata,   // key, value
    input  wire                     i_s_axis_tuser,   // kind
    // results
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    output logic [VAL_W-1:0]        o_m_axis_tdata,   // read_value
    output logic                    o_m_axis_tuser    // hit
);

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW    = IW;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MW    = AW + VAL_W + KEY_W;
    localparam int CAP_INIT = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;
    localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(ENTRIES);

    // entry memory: {age, value, key}
    logic [MW-1:0]      r_mem [ENTRIES];
    logic [MW-1:0]      r_rd_data;

    t_state             r_state;
    t_state             n_state;

    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cap;

    logic [CNT_W-1:0]   r_idx;
    logic               r_chk;
    logic [IW-1:0]      r_chk_idx;

    // current item
    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;

    // scan results
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [AW-1:0]      r_hit_age;
    logic [VAL_W-1:0]   r_hit_val;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_vic_found;
    logic [IW-1:0]      r_vic_idx;
    logic [AW-1:0]      r_vic_age;

    // update plan
    logic [IW-1:0]      r_tgt_idx;
    logic [AW-1:0]      r_old_rank;
    logic               r_inc_all;
    logic [VAL_W-1:0]   r_tgt_val;

    // output register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [VAL_W-1:0]   r_out_data;

    // control
    logic               in_xfer;
    logic               issue;
    logic               out_free;
    logic               out_load;
    logic               mem_we;
    logic [MW-1:0]      mem_wd;
    logic               cap_we;
    logic [CNT_W-1:0]   cap_clamped;
    logic [CMP_W-1:0]   cfg_ext;
    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic [AW-1:0]      rd_age;
    logic               full;

    assign rd_key   = r_rd_data[KEY_W-1:0];
    assign rd_val   = r_rd_data[KEY_W+VAL_W-1:KEY_W];
    assign rd_age   = r_rd_data[MW-1:KEY_W+VAL_W];
    assign rd_valid = r_valid[r_chk_idx];
    assign full     = (r_count >= r_cap);
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign cfg_ext = CMP_W'(i_cfg_data);
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cap_clamped = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(ENTRIES)) begin
            cap_clamped = N_CNT;
        end else begin
            cap_clamped = CNT_W'(cfg_ext);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_chk && (r_chk_idx == LAST_IDX)) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = (r_kind == KIND_GET) ? ST_EMIT : ST_UPD;
            end
            ST_EMIT: begin
                if (out_free) n_state = r_hit ? ST_UPD : ST_IDLE;
            end
            ST_UPD: begin
                if (r_chk && (r_chk_idx == LAST_IDX)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_wd          = r_rd_data;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                issue = (r_idx < N_CNT);
            end
            ST_DECIDE: begin
            end
            ST_EMIT: begin
                out_load = out_free;
            end
            ST_UPD: begin
                issue = (r_idx < N_CNT);
                if (r_chk) begin
                    if (r_chk_idx == r_tgt_idx) begin
                        mem_we = 1'b1;
                        mem_wd = {AW'(0), r_tgt_val, r_key};
                    end else if (rd_valid && (r_inc_all || (rd_age < r_old_rank))) begin
                        mem_we = 1'b1;
                        mem_wd = {rd_age + AW'(1), rd_val, rd_key};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign in_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign cap_we      = i_cfg_valid && (r_count == '0);

    // entry memory: one write and one registered read per cycle; the update
    // sweep writes the entry read the cycle before, never the one read now
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_chk_idx] <= mem_wd;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_INIT);
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= issue;
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end else if (r_state != ST_SCAN && r_state != ST_UPD) begin
                r_idx <= '0;
            end
            if (cap_we) begin
                r_cap <= cap_clamped;
            end
            // insert into a free slot
            if (r_state == ST_DECIDE && r_kind == KIND_PUT && !r_hit && !full) begin
                r_valid[r_free_idx] <= 1'b1;
                r_count             <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx[IW-1:0];
        if (in_xfer) begin
            r_kind       <= i_s_axis_tuser;
            r_key        <= i_s_axis_tdata[KEY_W-1:0];
            r_val        <= i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (r_state == ST_SCAN && r_chk) begin
            if (rd_valid && (rd_key == r_key)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_chk_idx;
                r_hit_age <= rd_age;
                r_hit_val <= rd_val;
            end
            if (!rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_chk_idx;
            end
            // ties go to the higher slot
            if (rd_valid && (!r_vic_found || (rd_age >= r_vic_age))) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_chk_idx;
                r_vic_age   <= rd_age;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_tgt_val <= (r_kind == KIND_PUT) ? r_val : r_hit_val;
            priority if (r_hit) begin
                r_tgt_idx  <= r_hit_idx;
                r_old_rank <= r_hit_age;
                r_inc_all  <= 1'b0;
            end else if (!full) begin
                r_tgt_idx  <= r_free_idx;
                r_old_rank <= '0;
                r_inc_all  <= 1'b1;
            end else begin
                r_tgt_idx  <= r_vic_idx;
                r_old_rank <= r_vic_age;
                r_inc_all  <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_hit ? r_hit_val : MISS_VALUE;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_hit;

    `ASSERT_ALWAYS(a_count_le_cap, i_clk, i_rst_n, r_count <= r_cap, "occupancy above capacity")
    `ASSERT_ALWAYS(a_count_matches_valid, i_clk, i_rst_n,
        $countones(r_valid) == r_count, "occupancy count disagrees with valid bits")
    `ASSERT_IMPLY(a_miss_value, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tdata == MISS_VALUE, "miss result without all-ones value")
    `ASSERT_IMPLY(a_target_valid, i_clk, i_rst_n, r_state == ST_UPD,
        r_valid[r_tgt_idx], "rank update aimed at an empty slot")

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the LRU key/value cache: directed and random get/put traffic.
module tb;
    import lkvc_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int POOL_SIZE    = 20;
    localparam int PHASE_ITEMS  = 300;
    localparam int SETTLE       = 2 * ENTRIES + 8;   // a put may still be sweeping
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;

    // Shadow copy of the cache contents and the replies still owed by the block.
    class cache_tracker;
        bit               slot_used [ENTRIES];
        logic [KEY_W-1:0] slot_key  [ENTRIES];
        logic [VAL_W-1:0] slot_val  [ENTRIES];
        int               slot_rank [ENTRIES];
        int               used_count;
        int               cap;
        logic [VAL_W:0]   replies_due [$];        // {hit, value}
        int               mismatches;
        int               gets;
        int               hits;
        int               puts;

        function new();
            used_count = 0;
            cap        = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;
            mismatches = 0;
            gets       = 0;
            hits       = 0;
            puts       = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // capacity only sticks while nothing is stored
        function void take_capacity(logic [CFG_W-1:0] v);
            if (used_count != 0) return;
            if (v == 0) cap = 1;
            else if (v > ENTRIES) cap = ENTRIES;
            else cap = v;
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function void make_newest(int s, int old_rank);
            for (int i = 0; i < ENTRIES; i++)
                if (i != s && slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function void take_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            int s;
            int slot;
            int victim;
            int worst;
            s = find_slot(key);
            if (kind == KIND_GET) begin
                gets++;
                if (s >= 0) begin
                    hits++;
                    replies_due.push_back({1'b1, slot_val[s]});
                    make_newest(s, slot_rank[s]);
                end else begin
                    replies_due.push_back({1'b0, MISS_VALUE});
                end
                return;
            end
            puts++;
            if (s >= 0) begin
                slot_val[s] = val;
                make_newest(s, slot_rank[s]);
                return;
            end
            if (used_count < cap) begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!slot_used[i] && slot < 0) slot = i;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i]) slot_rank[i]++;
                slot_used[slot] = 1'b1;
                slot_key[slot]  = key;
                slot_val[slot]  = val;
                slot_rank[slot] = 0;
                used_count++;
            end else begin
                // evict the least recent entry; ties go to the highest slot
                victim = -1;
                worst  = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && (victim < 0 || slot_rank[i] >= worst)) begin
                        victim = i;
                        worst  = slot_rank[i];
                    end
                slot_key[victim] = key;
                slot_val[victim] = val;
                make_newest(victim, worst);
            end
        endfunction

        function void check_reply(logic hit, logic [VAL_W-1:0] val);
            logic [VAL_W:0] want;
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: reply with none pending: expected nothing, got hit=%0b value=%h",
                         $time, hit, val);
                return;
            end
            want = replies_due.pop_front();
            if (hit !== want[VAL_W]) begin
                mismatches++;
                $display("%0t: hit mismatch: expected %0b, got %0b", $time, want[VAL_W], hit);
            end
            if (val !== want[VAL_W-1:0]) begin
                mismatches++;
                $display("%0t: read_value mismatch: expected %h, got %h",
                         $time, want[VAL_W-1:0], val);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [KEY_W+VAL_W-1:0] i_s_axis_tdata;    // key, value
    logic                   i_s_axis_tuser;    // kind
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [VAL_W-1:0]       o_m_axis_tdata;    // read_value
    logic                   o_m_axis_tuser;    // hit

    cache_tracker     tracker;
    bit               steady;
    bit               hold_replies;
    int               quiet_cycles;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // called at a falling edge, returns at a falling edge
    task automatic write_capacity(logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.take_capacity(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        if (!steady && $urandom_range(99) < 31) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2 * ENTRIES + 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {val, key};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.take_request(kind, key, val);
        @(negedge i_clk);
    endtask

    task automatic wait_settled();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // reply side: random back-pressure, plus one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_replies) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_replies = 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_reply(o_m_axis_tuser, o_m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
                     $time, quiet_cycles, tracker.replies_due.size());
            $display("** lru_key_value_cache: FAILED **");
            $finish;
        end
    end

    initial begin
        int               sel;
        int               fill;
        logic             kind;
        logic [KEY_W-1:0] key;

        tracker         = new();
        steady          = 1'b0;
        hold_replies    = 1'b0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_GET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // capacity while empty: saturation at both ends, then the working value
        write_capacity(5'd31);
        write_capacity(5'd0);
        write_capacity(5'd1);
        write_capacity(5'd16);
        sel = $urandom_range(7);
        if (sel == 0) write_capacity(5'd1);
        else if (sel < 3) write_capacity(5'd16);
        else write_capacity(5'($urandom_range(2, 15)));

        // directed: empty lookup, extreme keys and values, update, eviction at small capacity
        send_request(KIND_GET, 32'h0000_0000, 32'h0);
        send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // hit value equals the miss pattern
        send_request(KIND_GET, 32'h8000_0000, 32'h0);
        send_request(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_GET, 32'h0000_0000, 32'h0);
        send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_PUT, 32'h8000_0000, 32'h1234_5678);
        send_request(KIND_GET, 32'h8000_0000, 32'h0);
        send_request(KIND_GET, 32'h0000_0001, 32'h0);
        fill = (tracker.cap <= 8) ? tracker.cap + 1 : 2;
        for (int i = 0; i < fill; i++)
            send_request(KIND_PUT, 32'h0000_0100 + i, $urandom);
        send_request(KIND_GET, 32'h0000_0100, 32'h0);
        send_request(KIND_GET, 32'h7FFF_FFFF, 32'h0);
        wait_settled();

        // random phases over a small key pool so hits and evictions are frequent
        for (int phase = 0; phase < 4; phase++) begin
            // capacity writes from here on are ignored since the store is occupied
            write_capacity(5'($urandom_range(31)));
            steady = (phase == 1);
            if (phase == 2) hold_replies = 1'b1;
            foreach (key_pool[i]) key_pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = 1'($urandom_range(1));
                key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : $urandom;
                send_request(kind, key, $urandom);
            end
            wait_settled();
        end
        steady = 1'b0;

        $display("Run covered %0d gets (%0d hits) and %0d puts at capacity %0d,",
                 tracker.gets, tracker.hits, tracker.puts, tracker.cap);
        $display("with eviction, updates, back-pressure and one long reply hold-off.");
        if (tracker.replies_due.size() != 0)
            $display("%0t: %0d expected replies never arrived",
                     $time, tracker.replies_due.size());
        if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
            $display("** lru_key_value_cache: PASSED **");
        else
            $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

endmodule
